>>> sv/owm_pkg.sv
// Shared types and constants of the 1-Wire temperature read master.
// No dependencies; imported by the configuration, tick logic and top modules.
package owm_pkg;

  // Command opcodes carried with each tick
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_RESET     = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ      = 3'd3;
  localparam logic [2:0] OP_CONVERT   = 3'd4;
  localparam logic [2:0] OP_READ_TEMP = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WT  = 3'd1;
  localparam logic [2:0] CFG_RESET_TAIL   = 3'd2;
  localparam logic [2:0] CFG_SHORT_LOW    = 3'd3;
  localparam logic [2:0] CFG_ZERO_LOW     = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] CFG_SLOT_LEN     = 3'd6;

  // Device command bytes
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REC   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REC   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ITEM_NONE  = 2'd0,
    ITEM_RESET = 2'd1,
    ITEM_WRITE = 2'd2,
    ITEM_READ  = 2'd3
  } item_kind_e;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [9:0] presence_wait;
    logic [9:0] reset_tail;
    logic [7:0] short_low;
    logic [7:0] zero_low;
    logic [7:0] read_sample;
    logic [7:0] slot_len;
  } owm_cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    logic               presence;
    logic [7:0]         rx_byte;
    logic signed [15:0] temperature;
    logic               line_idle_high;
  } owm_res_t;

endpackage

>>> sv/owm_cfg.sv
// Timing configuration registers of the 1-Wire master.
// Depends on owm_pkg for register indexes and the configuration struct.
module owm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [2:0]        index_i,
  input  logic [9:0]        data_i,
  output owm_pkg::owm_cfg_t cfg_o
);
  import owm_pkg::*;

  owm_cfg_t cfg_q, cfg_d;

  // Decode the write beat onto one register
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        CFG_RESET_LOW:   cfg_d.reset_low     = data_i;
        CFG_PRESENCE_WT: cfg_d.presence_wait = data_i;
        CFG_RESET_TAIL:  cfg_d.reset_tail    = data_i;
        CFG_SHORT_LOW:   cfg_d.short_low     = data_i[7:0];
        CFG_ZERO_LOW:    cfg_d.zero_low      = data_i[7:0];
        CFG_READ_SAMPLE: cfg_d.read_sample   = data_i[7:0];
        CFG_SLOT_LEN:    cfg_d.slot_len      = data_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= 10'd480;
      cfg_q.presence_wait <= 10'd70;
      cfg_q.reset_tail    <= 10'd410;
      cfg_q.short_low     <= 8'd6;
      cfg_q.zero_low      <= 8'd60;
      cfg_q.read_sample   <= 8'd9;
      cfg_q.slot_len      <= 8'd70;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/owm_core.sv
// Per-tick phase, timer and shift logic of the 1-Wire master with its state.
// Depends on owm_pkg for phases, opcodes, command bytes and structs.
module owm_core #(
  parameter int TIMER_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  owm_pkg::owm_cfg_t cfg_i,
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        tx_byte_i,
  input  logic              line_i,
  output owm_pkg::owm_res_t res_o
);
  import owm_pkg::*;

  localparam logic [16:0] TMax = 17'((18'd1 << TIMER_BITS) - 18'd1);
  localparam logic [TIMER_BITS-1:0] TOne = {{(TIMER_BITS-1){1'b0}}, 1'b1};

  phase_e                ph_q, ph_d;
  logic [TIMER_BITS-1:0] tim_q, tim_d;
  logic [2:0]            bit_q, bit_d;
  logic [7:0]            sh_q, sh_d;
  logic [2:0]            step_q, step_d;
  logic                  pres_q, pres_d;
  logic [7:0]            rx_q, rx_d;
  logic [7:0]            tlo_q, tlo_d;
  logic [15:0]           temp_q, temp_d;
  logic [2:0]            cmd_q, cmd_d;
  logic [7:0]            txl_q, txl_d;

  logic        done;
  logic        idle_line;
  logic        ld;
  logic [10:0] dur;
  logic        begin_req;
  logic        fin_read;
  logic [7:0]  low;
  logic [9:0]  used;
  logic [9:0]  v10;
  logic [16:0] v17;
  item_kind_e  kind;
  logic [7:0]  ibyte;

  function automatic logic [7:0] lo1(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] wlow(input logic b, input logic [7:0] s,
                                      input logic [7:0] z);
    return lo1(b ? s : z);
  endfunction

  // Which bus item a command runs at a given step of its sequence
  function automatic item_kind_e item_kind(input logic [2:0] c, input logic [2:0] s);
    item_kind_e k;
    k = ITEM_NONE;
    case (c)
      OP_RESET: if (s == 3'd0) k = ITEM_RESET;
      OP_WRITE: if (s == 3'd0) k = ITEM_WRITE;
      OP_READ:  if (s == 3'd0) k = ITEM_READ;
      OP_CONVERT: begin
        if (s == 3'd0) k = ITEM_RESET;
        else if (s == 3'd1 || s == 3'd2) k = ITEM_WRITE;
      end
      OP_READ_TEMP: begin
        if (s == 3'd0) k = ITEM_RESET;
        else if (s == 3'd1 || s == 3'd2) k = ITEM_WRITE;
        else if (s == 3'd3 || s == 3'd4) k = ITEM_READ;
      end
      default: k = ITEM_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] item_byte(input logic [2:0] c, input logic [2:0] s,
                                           input logic [7:0] tx);
    logic [7:0] b;
    b = 8'd0;
    if (c == OP_WRITE) b = tx;
    else if (s == 3'd1) b = CMD_SKIP_ROM;
    else if (c == OP_CONVERT) b = CMD_CONVERT;
    else b = CMD_READ_PAD;
    return b;
  endfunction

  // Advance the bus machine by one microsecond tick
  always_comb begin
    ph_d      = ph_q;
    tim_d     = tim_q;
    bit_d     = bit_q;
    sh_d      = sh_q;
    step_d    = step_q;
    pres_d    = pres_q;
    rx_d      = rx_q;
    tlo_d     = tlo_q;
    temp_d    = temp_q;
    cmd_d     = cmd_q;
    txl_d     = txl_q;
    done      = 1'b0;
    idle_line = 1'b0;
    ld        = 1'b0;
    dur       = 11'd0;
    begin_req = 1'b0;
    fin_read  = 1'b0;
    low       = 8'd0;
    used      = 10'd0;

    if (ph_q == PH_IDLE) begin
      idle_line = line_i;
      case (opcode_i) inside
        OP_RESET, OP_WRITE, OP_READ, OP_CONVERT, OP_READ_TEMP: begin
          cmd_d     = opcode_i;
          txl_d     = tx_byte_i;
          step_d    = 3'd0;
          begin_req = 1'b1;
        end
        default: ;
      endcase
    end else if (tim_q != '0) begin
      tim_d = tim_q - TOne;
    end else begin
      unique case (ph_q)
        PH_RST_LOW: begin
          ph_d = PH_RST_WAIT;
          ld   = 1'b1;
          dur  = {1'b0, cfg_i.presence_wait} + 11'd1;
        end
        PH_RST_WAIT: begin
          pres_d = ~line_i;
          if (!line_i) begin
            if (cfg_i.reset_tail != 10'd0) begin
              ph_d = PH_RST_TAIL;
              ld   = 1'b1;
              dur  = {1'b0, cfg_i.reset_tail};
            end else begin
              step_d    = step_q + 3'd1;
              begin_req = 1'b1;
            end
          end else begin
            // no device answered: abort
            ph_d = PH_IDLE;
            ld   = 1'b1;
            done = 1'b1;
          end
        end
        PH_RST_TAIL: begin
          step_d    = step_q + 3'd1;
          begin_req = 1'b1;
        end
        PH_WR_LOW: begin
          low  = wlow(sh_q[0], cfg_i.short_low, cfg_i.zero_low);
          ph_d = PH_WR_REC;
          ld   = 1'b1;
          dur  = (cfg_i.slot_len > low) ? {3'd0, cfg_i.slot_len - low} : 11'd1;
        end
        PH_WR_REC: begin
          sh_d = {1'b0, sh_q[7:1]};
          if (bit_q == 3'd7) begin
            step_d    = step_q + 3'd1;
            begin_req = 1'b1;
          end else begin
            bit_d = bit_q + 3'd1;
            ph_d  = PH_WR_LOW;
            ld    = 1'b1;
            dur   = {3'd0, wlow(sh_q[1], cfg_i.short_low, cfg_i.zero_low)};
          end
        end
        PH_RD_LOW: begin
          ph_d = PH_RD_WAIT;
          ld   = 1'b1;
          dur  = {3'd0, cfg_i.read_sample} + 11'd1;
        end
        PH_RD_WAIT: begin
          sh_d = {line_i, sh_q[7:1]};
          used = {2'd0, lo1(cfg_i.short_low)} + {2'd0, cfg_i.read_sample} + 10'd1;
          if ({2'd0, cfg_i.slot_len} > used) begin
            ph_d = PH_RD_REC;
            ld   = 1'b1;
            dur  = {1'b0, {2'd0, cfg_i.slot_len} - used};
          end else begin
            fin_read = 1'b1;
          end
        end
        PH_RD_REC: fin_read = 1'b1;
        default: begin
          ph_d = PH_IDLE;
          ld   = 1'b1;
        end
      endcase
    end

    // Close a read bit: store the byte or start the next slot
    if (fin_read) begin
      if (bit_q == 3'd7) begin
        rx_d = sh_d;
        if (cmd_q == OP_READ_TEMP && step_q == 3'd3) tlo_d = sh_d;
        if (cmd_q == OP_READ_TEMP && step_q == 3'd4) temp_d = {sh_d, tlo_q};
        step_d    = step_q + 3'd1;
        begin_req = 1'b1;
      end else begin
        bit_d = bit_q + 3'd1;
        ph_d  = PH_RD_LOW;
        ld    = 1'b1;
        dur   = {3'd0, lo1(cfg_i.short_low)};
      end
    end

    // Start the bus item of the current sequence step
    kind  = item_kind(cmd_d, step_d);
    ibyte = item_byte(cmd_d, step_d, txl_d);
    if (begin_req) begin
      ld = 1'b1;
      unique case (kind)
        ITEM_RESET: begin
          ph_d = PH_RST_LOW;
          dur  = {1'b0, cfg_i.reset_low == 10'd0 ? 10'd1 : cfg_i.reset_low};
        end
        ITEM_WRITE: begin
          sh_d  = ibyte;
          bit_d = 3'd0;
          ph_d  = PH_WR_LOW;
          dur   = {3'd0, wlow(ibyte[0], cfg_i.short_low, cfg_i.zero_low)};
        end
        ITEM_READ: begin
          sh_d  = 8'd0;
          bit_d = 3'd0;
          ph_d  = PH_RD_LOW;
          dur   = {3'd0, lo1(cfg_i.short_low)};
        end
        default: begin
          ph_d = PH_IDLE;
          dur  = 11'd0;
          done = 1'b1;
        end
      endcase
    end

    // Load the timer with the saturated duration minus one
    v10 = (dur == 11'd0) ? 10'd0 : 10'(dur - 11'd1);
    v17 = {7'd0, v10};
    if (ld) tim_d = (v17 > TMax) ? TMax[TIMER_BITS-1:0] : v17[TIMER_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tim_q  <= '0;
      bit_q  <= 3'd0;
      sh_q   <= 8'd0;
      step_q <= 3'd0;
      pres_q <= 1'b0;
      rx_q   <= 8'd0;
      tlo_q  <= 8'd0;
      temp_q <= 16'd0;
      cmd_q  <= OP_TICK;
      txl_q  <= 8'd0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      tim_q  <= tim_d;
      bit_q  <= bit_d;
      sh_q   <= sh_d;
      step_q <= step_d;
      pres_q <= pres_d;
      rx_q   <= rx_d;
      tlo_q  <= tlo_d;
      temp_q <= temp_d;
      cmd_q  <= cmd_d;
      txl_q  <= txl_d;
    end
  end

  // Result of this tick, taken from the next state
  always_comb begin
    res_o.drive_low      = (ph_d == PH_RST_LOW) || (ph_d == PH_WR_LOW) ||
                           (ph_d == PH_RD_LOW);
    res_o.busy           = (ph_d != PH_IDLE);
    res_o.done           = done;
    res_o.presence       = pres_d;
    res_o.rx_byte        = rx_d;
    res_o.temperature    = $signed(temp_d);
    res_o.line_idle_high = idle_line;
  end

endmodule

>>> sv/onewire_master_temp_read_top.sv
// Top level of the 1-Wire temperature read master: handshakes and result register.
// Depends on owm_pkg, owm_cfg and owm_core.
//
// Each input beat is one microsecond tick of the bus: it carries the sampled
// wire level and, when the master is idle, an optional command (bus reset,
// write byte, read byte, start conversion, read temperature). Every tick
// yields exactly one result beat with the drive level for the next
// microsecond, busy, a one-tick done pulse, presence, the last byte read, the
// raw temperature in 1/16 degree units and the idle line level. The phase,
// timer and shift update is a single pass of logic into the state registers,
// and the result register takes a new tick whenever it is empty or its beat
// is being taken in the same cycle, so one beat per cycle is sustained.
// Timing registers are to be written over the config channel only while no
// tick is in flight; the block does not enforce this. The write channel is always ready.
module onewire_master_temp_read_top #(
  parameter int TIMER_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               line_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               presence_o,
  output logic [7:0]         rx_byte_o,
  output logic signed [15:0] temperature_o,
  output logic               line_idle_high_o
);
  import owm_pkg::*;

  owm_cfg_t cfg;
  owm_res_t res;
  owm_res_t res_q;
  logic     out_valid_q;
  logic     in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  owm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  owm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .cfg_i     (cfg),
    .opcode_i  (opcode_i),
    .tx_byte_i (tx_byte_i),
    .line_i    (line_level_i),
    .res_o     (res)
  );

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = res_q.drive_low;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign presence_o       = res_q.presence;
  assign rx_byte_o        = res_q.rx_byte;
  assign temperature_o    = res_q.temperature;
  assign line_idle_high_o = res_q.line_idle_high;

  // The bus is only pulled low while a command runs
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!drive_low_o || busy_res_o))
    else $error("drive_low without busy");

  // Done marks the end of a command
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && busy_res_o))
    else $error("done while still busy");

  // An accepted tick always produces a result beat next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick gave no result");

endmodule

>>> tb/owm_tick_checker.sv
`timescale 1ns / 1ps
// Result checker for the 1-Wire temperature read master: tracks timing writes, predicts
// one result per tick beat and compares every result beat. Depends on owm_pkg.
module owm_tick_checker #(
  parameter int TIMER_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               line_level_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               drive_low_i,
  input  logic               busy_res_i,
  input  logic               done_res_i,
  input  logic               presence_i,
  input  logic [7:0]         rx_byte_i,
  input  logic signed [15:0] temperature_i,
  input  logic               line_idle_high_i,
  output int                 errors_o,
  output int                 pending_o
);
  import owm_pkg::*;

  // Shadow copy of the timing registers and of the sequencer state
  owm_cfg_t              cfg;
  phase_e                ph;
  logic [TIMER_BITS-1:0] timer;
  logic [2:0]            bit_idx;
  logic [7:0]            shreg;
  logic [2:0]            step;
  logic                  pres;
  logic [7:0]            rxb;
  logic [7:0]            temp_lo;
  logic [15:0]           temp;
  logic [2:0]            cmd;
  logic [7:0]            tx_held;
  logic                  done;

  owm_res_t tick_results[$];
  int       mismatches;
  int       out_count;

  function automatic int at_least_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Load a phase that lasts dur ticks; clamp to what the timer can hold
  function automatic void load_phase(phase_e p, int dur);
    int v;
    int maxv;
    maxv = (1 << TIMER_BITS) - 1;
    v = (dur == 0) ? 0 : dur - 1;
    ph = p;
    timer = TIMER_BITS'((v > maxv) ? maxv : v);
  endfunction

  function automatic int write_low();
    return at_least_one(shreg[0] ? int'(cfg.short_low) : int'(cfg.zero_low));
  endfunction

  // Start the current step of the latched command, or finish when none is left
  function automatic void start_item();
    item_kind_e kind;
    logic [7:0] b;
    kind = ITEM_NONE;
    b = '0;
    case (cmd) inside
      OP_RESET: if (step == 0) kind = ITEM_RESET;
      OP_WRITE: if (step == 0) begin
        kind = ITEM_WRITE;
        b = tx_held;
      end
      OP_READ: if (step == 0) kind = ITEM_READ;
      OP_CONVERT, OP_READ_TEMP: begin
        if (step == 0) kind = ITEM_RESET;
        else if (step == 1) begin
          kind = ITEM_WRITE;
          b = CMD_SKIP_ROM;
        end else if (step == 2) begin
          kind = ITEM_WRITE;
          b = (cmd == OP_CONVERT) ? CMD_CONVERT : CMD_READ_PAD;
        end else if (cmd == OP_READ_TEMP && (step == 3 || step == 4)) begin
          kind = ITEM_READ;
        end
      end
      default: ;
    endcase
    case (kind)
      ITEM_RESET: load_phase(PH_RST_LOW, at_least_one(int'(cfg.reset_low)));
      ITEM_WRITE: begin
        shreg = b;
        bit_idx = '0;
        load_phase(PH_WR_LOW, write_low());
      end
      ITEM_READ: begin
        shreg = '0;
        bit_idx = '0;
        load_phase(PH_RD_LOW, at_least_one(int'(cfg.short_low)));
      end
      default: begin
        ph = PH_IDLE;
        timer = '0;
        done = 1'b1;
      end
    endcase
  endfunction

  function automatic void advance_item();
    step = step + 3'd1;
    start_item();
  endfunction

  // Close a read slot: store the byte after the eighth bit
  function automatic void finish_read_bit();
    if (bit_idx == 3'd7) begin
      rxb = shreg;
      if (cmd == OP_READ_TEMP && step == 3) temp_lo = shreg;
      if (cmd == OP_READ_TEMP && step == 4) temp = {shreg, temp_lo};
      advance_item();
    end else begin
      bit_idx = bit_idx + 3'd1;
      load_phase(PH_RD_LOW, at_least_one(int'(cfg.short_low)));
    end
  endfunction

  // Leave the current phase once its timer has run out
  function automatic void end_phase(logic lvl);
    int low;
    int used;
    case (ph)
      PH_RST_LOW: load_phase(PH_RST_WAIT, int'(cfg.presence_wait) + 1);
      PH_RST_WAIT: begin
        pres = ~lvl;
        if (!pres) begin
          ph = PH_IDLE;
          timer = '0;
          done = 1'b1;
        end else if (cfg.reset_tail != 0) begin
          load_phase(PH_RST_TAIL, int'(cfg.reset_tail));
        end else begin
          advance_item();
        end
      end
      PH_RST_TAIL: advance_item();
      PH_WR_LOW: begin
        low = write_low();
        load_phase(PH_WR_REC, (int'(cfg.slot_len) > low) ? int'(cfg.slot_len) - low : 1);
      end
      PH_WR_REC: begin
        shreg = shreg >> 1;
        if (bit_idx == 3'd7) begin
          advance_item();
        end else begin
          bit_idx = bit_idx + 3'd1;
          load_phase(PH_WR_LOW, write_low());
        end
      end
      PH_RD_LOW: load_phase(PH_RD_WAIT, int'(cfg.read_sample) + 1);
      PH_RD_WAIT: begin
        shreg = {lvl, shreg[7:1]};
        used = at_least_one(int'(cfg.short_low)) + int'(cfg.read_sample) + 1;
        if (int'(cfg.slot_len) > used) load_phase(PH_RD_REC, int'(cfg.slot_len) - used);
        else finish_read_bit();
      end
      PH_RD_REC: finish_read_bit();
      default: begin
        ph = PH_IDLE;
        timer = '0;
      end
    endcase
  endfunction

  // One microsecond of the master: accept a command when idle, else run the timer
  function automatic owm_res_t master_tick(logic [2:0] op, logic [7:0] txb, logic lvl);
    owm_res_t r;
    logic idle_lvl;
    idle_lvl = 1'b0;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      idle_lvl = lvl;
      if (op >= OP_RESET && op <= OP_READ_TEMP) begin
        cmd = op;
        tx_held = txb;
        step = '0;
        start_item();
      end
    end else if (timer != '0) begin
      timer = timer - 1'b1;
    end else begin
      end_phase(lvl);
    end
    r.drive_low = (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW);
    r.busy = (ph != PH_IDLE);
    r.done = done;
    r.presence = pres;
    r.rx_byte = rxb;
    r.temperature = temp;
    r.line_idle_high = idle_lvl;
    return r;
  endfunction

  // Check result beats, queue the prediction for a tick beat, then apply timing writes
  always @(posedge clk_i or negedge rst_ni) begin : track
    owm_res_t seen;
    owm_res_t due;
    if (!rst_ni) begin
      cfg.reset_low = 10'd480;
      cfg.presence_wait = 10'd70;
      cfg.reset_tail = 10'd410;
      cfg.short_low = 8'd6;
      cfg.zero_low = 8'd60;
      cfg.read_sample = 8'd9;
      cfg.slot_len = 8'd70;
      ph = PH_IDLE;
      timer = '0;
      bit_idx = '0;
      shreg = '0;
      step = '0;
      pres = 1'b0;
      rxb = '0;
      temp_lo = '0;
      temp = '0;
      cmd = OP_TICK;
      tx_held = '0;
      done = 1'b0;
      tick_results.delete();
      mismatches = 0;
      out_count = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        out_count++;
        seen.drive_low = drive_low_i;
        seen.busy = busy_res_i;
        seen.done = done_res_i;
        seen.presence = presence_i;
        seen.rx_byte = rx_byte_i;
        seen.temperature = temperature_i;
        seen.line_idle_high = line_idle_high_i;
        if (tick_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no tick pending", out_count);
        end else begin
          due = tick_results.pop_front();
          if (seen !== due) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d exp/act: drv %b/%b busy %b/%b done %b/%b pres %b/%b",
                       out_count, due.drive_low, seen.drive_low, due.busy, seen.busy,
                       due.done, seen.done, due.presence, seen.presence,
                       " rx %h/%h temp %0d/%0d idle %b/%b", due.rx_byte, seen.rx_byte,
                       due.temperature, seen.temperature, due.line_idle_high,
                       seen.line_idle_high);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        tick_results.push_back(master_tick(opcode_i, tx_byte_i, line_level_i));
      // A timing write takes effect from the next tick on
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RESET_LOW:   cfg.reset_low = cfg_data_i;
          CFG_PRESENCE_WT: cfg.presence_wait = cfg_data_i;
          CFG_RESET_TAIL:  cfg.reset_tail = cfg_data_i;
          CFG_SHORT_LOW:   cfg.short_low = cfg_data_i[7:0];
          CFG_ZERO_LOW:    cfg.zero_low = cfg_data_i[7:0];
          CFG_READ_SAMPLE: cfg.read_sample = cfg_data_i[7:0];
          CFG_SLOT_LEN:    cfg.slot_len = cfg_data_i[7:0];
          default: ;
        endcase
      end
      errors_o <= mismatches;
      pending_o <= tick_results.size();
    end
  end

endmodule

>>> tb/onewire_master_temp_read_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the 1-Wire temperature read master: drives tick and timing beats,
// paces the result side and reports the verdict. Depends on owm_pkg and owm_tick_checker.
module onewire_master_temp_read_top_tb;
  import owm_pkg::*;

  localparam int TIMER_BITS = 10;
  // Opcodes and register index outside the defined sets
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [2:0] CFG_NONE   = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [9:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         opcode_i;
  logic [7:0]         tx_byte_i;
  logic               line_level_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               drive_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic               presence_o;
  logic [7:0]         rx_byte_o;
  logic signed [15:0] temperature_o;
  logic               line_idle_high_o;

  int errors;
  int pending;

  // Stimulus bookkeeping
  int in_beats = 0;
  int out_beats = 0;
  int last_idle_beat = 0;
  logic last_busy = 1'b0;
  int burst_left = 0;
  bit dev_present = 1'b1;

  onewire_master_temp_read_top #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .tx_byte_i       (tx_byte_i),
    .line_level_i    (line_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_low_o     (drive_low_o),
    .busy_res_o      (busy_res_o),
    .done_res_o      (done_res_o),
    .presence_o      (presence_o),
    .rx_byte_o       (rx_byte_o),
    .temperature_o   (temperature_o),
    .line_idle_high_o(line_idle_high_o)
  );

  owm_tick_checker #(
    .TIMER_BITS(TIMER_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .opcode_i        (opcode_i),
    .tx_byte_i       (tx_byte_i),
    .line_level_i    (line_level_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_low_i     (drive_low_o),
    .busy_res_i      (busy_res_o),
    .done_res_i      (done_res_o),
    .presence_i      (presence_o),
    .rx_byte_i       (rx_byte_o),
    .temperature_i   (temperature_o),
    .line_idle_high_i(line_idle_high_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Note where the master last reported idle, by result beat number
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      out_beats <= out_beats + 1;
      last_busy <= busy_res_o;
      if (!busy_res_o) last_idle_beat <= out_beats + 1;
    end
  end

  // Result side: stall on a rotating pattern, with an occasional long hold-off
  initial begin : receiver
    int hold_left;
    int slot;
    logic [15:0] pattern;
    bit pressure_done;
    out_ready_i = 1'b0;
    hold_left = 0;
    slot = 0;
    pattern = '1;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (slot == 0) pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      slot = (slot + 1) % 64;
      if (hold_left == 0 && rst_ni &&
          ((!pressure_done && out_beats >= 300) || $urandom_range(0, 9999) == 0)) begin
        hold_left = $urandom_range(150, 400);
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= pattern[slot % 16];
      end
    end
  end

  // Wire level for one tick: a present device mostly pulls low, an absent one rarely
  function automatic logic bus_level();
    if (dev_present) return ($urandom_range(0, 7) < 5) ? 1'b0 : 1'b1;
    return ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
  endfunction

  // Offer one tick beat; pause between bursts of random length
  task automatic send_tick(input logic [2:0] op, input logic [7:0] txb, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    tx_byte_i <= txb;
    line_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    in_beats++;
  endtask

  task automatic stop_ticks();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // Drain all results and keep ticking until the master reports idle
  task automatic settle();
    stop_ticks();
    while (pending != 0 || last_busy) begin
      if (pending == 0) begin
        repeat (16) send_tick(OP_TICK, 8'($urandom), bus_level());
        stop_ticks();
      end else begin
        @(posedge clk_i);
      end
    end
  endtask

  // Issue a command, then tick until a later result shows the master idle again;
  // noise sets how often a filler tick carries a random opcode
  task automatic run_command(input logic [2:0] op, input logic [7:0] txb, input bit present,
                             input int noise);
    int cmd_beat;
    logic [2:0] filler;
    dev_present = present;
    send_tick(op, txb, bus_level());
    cmd_beat = in_beats;
    while (last_idle_beat <= cmd_beat) begin
      filler = (noise != 0 && $urandom_range(1, noise) == 1) ? 3'($urandom) : OP_TICK;
      send_tick(filler, 8'($urandom), bus_level());
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                             input logic [9:0] tail, input logic [9:0] short_low,
                             input logic [9:0] zero_low, input logic [9:0] sample,
                             input logic [9:0] slot);
    write_reg(CFG_RESET_LOW, rst_low);
    write_reg(CFG_PRESENCE_WT, pres_wait);
    write_reg(CFG_RESET_TAIL, tail);
    write_reg(CFG_SHORT_LOW, short_low);
    write_reg(CFG_ZERO_LOW, zero_low);
    write_reg(CFG_READ_SAMPLE, sample);
    write_reg(CFG_SLOT_LEN, slot);
  endtask

  initial begin : stimulus
    logic [2:0] op;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_RESET_LOW;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OP_TICK;
    tx_byte_i = '0;
    line_level_i = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle ticks with both wire levels and the unused opcodes, reset timings
    send_tick(OP_TICK, 8'h00, 1'b0);
    send_tick(OP_TICK, 8'hFF, 1'b1);
    send_tick(OP_SPARE_6, 8'h00, 1'b1);
    send_tick(OP_SPARE_7, 8'hFF, 1'b0);
    run_command(OP_RESET, 8'h00, 1'b0, 0);
    settle();

    // Zero tail, zero low times, read slots shorter than low time plus sample
    load_timing(10'd3, 10'd2, 10'd0, 10'd0, 10'd0, 10'd1, 10'd2);
    write_reg(CFG_NONE, 10'h3FF);
    run_command(OP_WRITE, 8'h00, 1'b1, 0);
    run_command(OP_WRITE, 8'hFF, 1'b1, 0);
    run_command(OP_READ, 8'h00, 1'b1, 0);
    run_command(OP_CONVERT, 8'h00, 1'b1, 0);
    run_command(OP_READ_TEMP, 8'h00, 1'b1, 0);
    run_command(OP_RESET, 8'h00, 1'b0, 0);
    // Opcodes arriving while busy must be ignored
    run_command(OP_READ_TEMP, 8'h00, 1'b1, 3);
    settle();

    // Shortest timings, all zero
    load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_command(OP_READ_TEMP, 8'h00, 1'b1, 0);
    run_command(OP_WRITE, 8'h5A, 1'b1, 0);
    run_command(OP_CONVERT, 8'h00, 1'b1, 0);
    settle();

    // Slots with a recovery tail
    load_timing(10'd2, 10'd1, 10'd3, 10'd2, 10'd4, 10'd1, 10'd5);
    run_command(OP_READ, 8'h00, 1'b1, 0);
    run_command(OP_WRITE, 8'h3C, 1'b1, 0);
    settle();

    // Random phases: short timings, random upper bits on the byte-wide registers
    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      load_timing(10'($urandom_range(0, 4)), 10'($urandom_range(0, 3)),
                  ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(1, 3)),
                  {2'($urandom), 8'($urandom_range(0, 3))},
                  {2'($urandom), 8'($urandom_range(0, 4))},
                  {2'($urandom), 8'($urandom_range(0, 3))},
                  {2'($urandom), 8'($urandom_range(0, 8))});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_NONE, 10'($urandom));
      repeat (3) begin
        op = 3'($urandom_range(OP_READ_TEMP, OP_RESET));
        if ($urandom_range(0, 19) == 0) op = 3'($urandom);
        run_command(op, 8'($urandom), $urandom_range(0, 99) < 85, 32);
      end
      settle();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
